// ===== src/idsc_pkg.sv =====
// ----------------------------------------------------------------------------
// idsc_pkg
// Shared types and constants of the integer degree sine and cosine unit.
// ----------------------------------------------------------------------------
package idsc_pkg;

	// Result width, signed ten-thousandths.
	localparam int VALUE_BITS = 15;

	// The magnitude is split as 8 * q + low, with q reduced modulo 45 so that
	// 8 * (q mod 45) + low equals the magnitude modulo 360.
	localparam int LOW_BITS   = 3;
	localparam int CHUNK_BITS = 8;
	localparam int REM_BITS   = 6;
	localparam logic [REM_BITS:0] REM_MOD = 7'd45;

	localparam int DEG_BITS = 9;
	localparam logic [DEG_BITS-1:0] DEG_HALF    = 9'd180;
	localparam logic [DEG_BITS-1:0] DEG_QUARTER = 9'd90;
	localparam logic [DEG_BITS-1:0] DEG_EIGHTH  = 9'd45;

	// Polynomial argument: 0..45.
	localparam int ARG_BITS = 6;

	// Horner accumulator and the coefficients, highest power first.
	localparam int ACC_BITS = 32;
	localparam logic signed [ACC_BITS-1:0] LOW_COEF [4] = '{
		-32'sd81, -32'sd277, 32'sd1747900, -32'sd1600
	};
	localparam logic signed [ACC_BITS-1:0] HIGH_COEF [4] = '{
		32'sd336, -32'sd161420, 32'sd75484, 32'sd999960000
	};

	// Exact division of a 30-bit nonnegative value by a reciprocal multiply:
	// q = (n * RECIP) >> SHIFT for the divisors 10000 and 100000.
	localparam int NUM_BITS   = 30;
	localparam int RECIP_BITS = 31;
	localparam int PROD_BITS  = NUM_BITS + RECIP_BITS;
	localparam int QUOT_BITS  = 14;
	localparam logic [RECIP_BITS-1:0] LOW_RECIP  = 31'd1759218605;
	localparam int                    LOW_SHIFT  = 44;
	localparam logic [RECIP_BITS-1:0] HIGH_RECIP = 31'd1407374884;
	localparam int                    HIGH_SHIFT = 47;

	// Reduced angle handed from the modulo chain to the polynomial unit.
	typedef struct packed {
		logic                neg;
		logic [DEG_BITS-1:0] deg;
	} red_t;

endpackage

// ===== src/idsc_in_if.sv =====
// ----------------------------------------------------------------------------
// idsc_in_if
// Input channel: angle in whole degrees and the sine or cosine select.
// ----------------------------------------------------------------------------
interface idsc_in_if #(
	parameter int ANGLE_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] angle;
	logic                         op;

	modport source (output valid, output angle, output op, input ready);
	modport sink   (input valid, input angle, input op, output ready);
endinterface

// ===== src/idsc_out_if.sv =====
// ----------------------------------------------------------------------------
// idsc_out_if
// Output channel: sine or cosine in signed ten-thousandths.
// ----------------------------------------------------------------------------
interface idsc_out_if import idsc_pkg::*;;
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

// ===== src/idsc_mod45.sv =====
// ----------------------------------------------------------------------------
// idsc_mod45
// Pipelined modulo-45 reduction, one byte of the operand per stage, that
// rebuilds the angle modulo 360 from the remainder and the low three bits.
// ----------------------------------------------------------------------------
module idsc_mod45 import idsc_pkg::*; #(
	parameter int HI_BITS = 13
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [HI_BITS-1:0] in_hi,
	input  logic [LOW_BITS-1:0] in_low,
	input  logic               in_neg,
	output logic               out_valid,
	input  logic               out_ready,
	output red_t               out_red
);
	localparam int NCH = (HI_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
	localparam int PW  = NCH * CHUNK_BITS;

	logic                vld_s [NCH];
	logic [REM_BITS-1:0] rem_s [NCH];
	logic [PW-1:0]       hi_s  [NCH];
	logic [LOW_BITS-1:0] low_s [NCH];
	logic                neg_s [NCH];
	logic                en    [NCH];
	logic [PW-1:0]       in_pad;

	assign in_pad = PW'(in_hi);

	for (genvar j = 0; j < NCH; j++) begin : g_stage
		logic                prv_vld;
		logic [REM_BITS-1:0] prv_rem;
		logic [PW-1:0]       prv_hi;
		logic [LOW_BITS-1:0] prv_low;
		logic                prv_neg;
		logic                dn_ready;
		logic [REM_BITS-1:0] nxt_rem;

		if (j == 0) begin : g_first
			assign prv_vld = in_valid;
			assign prv_rem = '0;
			assign prv_hi  = in_pad;
			assign prv_low = in_low;
			assign prv_neg = in_neg;
		end else begin : g_next
			assign prv_vld = vld_s[j-1];
			assign prv_rem = rem_s[j-1];
			assign prv_hi  = hi_s[j-1];
			assign prv_low = low_s[j-1];
			assign prv_neg = neg_s[j-1];
		end

		if (j == NCH - 1) begin : g_last
			assign dn_ready = out_ready;
		end else begin : g_mid
			assign dn_ready = en[j+1];
		end

		assign en[j] = !vld_s[j] || dn_ready;

		// Shift in one bit at a time, most significant first, and subtract
		// the modulus whenever the partial remainder reaches it.
		always_comb begin : p_step
			logic [REM_BITS:0] acc;
			acc     = '0;
			nxt_rem = prv_rem;
			for (int b = CHUNK_BITS - 1; b >= 0; b--) begin
				acc = {nxt_rem, prv_hi[(NCH-1-j)*CHUNK_BITS + b]};
				if (acc >= REM_MOD) begin
					acc = acc - REM_MOD;
				end
				nxt_rem = acc[REM_BITS-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en[j]) begin
				vld_s[j] <= prv_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en[j] && prv_vld) begin
				rem_s[j] <= nxt_rem;
				hi_s[j]  <= prv_hi;
				low_s[j] <= prv_low;
				neg_s[j] <= prv_neg;
			end
		end
	end

	assign in_ready      = en[0];
	assign out_valid     = vld_s[NCH-1];
	assign out_red.neg   = neg_s[NCH-1];
	assign out_red.deg   = {rem_s[NCH-1], low_s[NCH-1]};
endmodule

// ===== src/idsc_poly.sv =====
// ----------------------------------------------------------------------------
// idsc_poly
// Quadrant fold, three Horner steps of the cubic, reciprocal division and
// sign, one register stage each.
// ----------------------------------------------------------------------------
module idsc_poly import idsc_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  red_t                         in_red,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [VALUE_BITS-1:0] out_value
);
	localparam int NST = 6;

	logic v_s [NST];
	logic en  [NST];

	// Stage payloads.
	logic                       sign_s1, sign_s2, sign_s3, sign_s4, sign_s5;
	logic                       hi_s1, hi_s2, hi_s3, hi_s4, hi_s5;
	logic [ARG_BITS-1:0]        arg_s1, arg_s2, arg_s3;
	logic signed [ACC_BITS-1:0] acc_s2, acc_s3, acc_s4;
	logic [PROD_BITS-1:0]       prod_s5;
	logic signed [VALUE_BITS-1:0] value_s6;

	// Handshake chain: a stage loads when it is empty or its successor moves.
	for (genvar k = 0; k < NST; k++) begin : g_ctl
		if (k == NST - 1) begin : g_last
			assign en[k] = !v_s[k] || out_ready;
		end else begin : g_mid
			assign en[k] = !v_s[k] || en[k+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				if (k == 0) begin
					v_s[k] <= in_valid;
				end else begin
					v_s[k] <= v_s[(k == 0) ? 0 : k-1];
				end
			end
		end
	end

	// Stage 1: fold into 0..90 and choose the polynomial.
	logic                neg_half;
	logic [DEG_BITS-1:0] half_deg;
	logic [DEG_BITS-1:0] quad_deg;
	logic                use_hi;
	logic [DEG_BITS-1:0] arg_deg;

	always_comb begin
		neg_half = in_red.deg > DEG_HALF;
		half_deg = neg_half ? in_red.deg - DEG_HALF : in_red.deg;
		quad_deg = (half_deg > DEG_QUARTER) ? DEG_HALF - half_deg : half_deg;
		use_hi   = quad_deg > DEG_EIGHTH;
		arg_deg  = use_hi ? DEG_QUARTER - quad_deg : quad_deg;
	end

	always_ff @(posedge clk) begin
		if (en[0] && in_valid) begin
			sign_s1 <= in_red.neg ^ neg_half;
			hi_s1   <= use_hi;
			arg_s1  <= arg_deg[ARG_BITS-1:0];
		end
	end

	// Stages 2 to 4: Horner steps, acc = acc * t + c.
	logic signed [ACC_BITS+ARG_BITS:0] mul_s2, mul_s3, mul_s4;
	logic signed [ACC_BITS-1:0]        lead_coef;

	always_comb begin
		lead_coef = hi_s1 ? HIGH_COEF[0] : LOW_COEF[0];
		mul_s2 = (ACC_BITS+ARG_BITS+1)'(lead_coef) * $signed({1'b0, arg_s1});
		mul_s3 = (ACC_BITS+ARG_BITS+1)'(acc_s2) * $signed({1'b0, arg_s2});
		mul_s4 = (ACC_BITS+ARG_BITS+1)'(acc_s3) * $signed({1'b0, arg_s3});
	end

	always_ff @(posedge clk) begin
		if (en[1] && v_s[0]) begin
			acc_s2  <= mul_s2[ACC_BITS-1:0] + (hi_s1 ? HIGH_COEF[1] : LOW_COEF[1]);
			arg_s2  <= arg_s1;
			hi_s2   <= hi_s1;
			sign_s2 <= sign_s1;
		end
		if (en[2] && v_s[1]) begin
			acc_s3  <= mul_s3[ACC_BITS-1:0] + (hi_s2 ? HIGH_COEF[2] : LOW_COEF[2]);
			arg_s3  <= arg_s2;
			hi_s3   <= hi_s2;
			sign_s3 <= sign_s2;
		end
		if (en[3] && v_s[2]) begin
			acc_s4  <= mul_s4[ACC_BITS-1:0] + (hi_s3 ? HIGH_COEF[3] : LOW_COEF[3]);
			hi_s4   <= hi_s3;
			sign_s4 <= sign_s3;
		end
	end

	// Stage 5: multiply by the reciprocal. Only the low cubic goes negative,
	// and only by less than its divisor, so a negative sum truncates to zero.
	logic [NUM_BITS-1:0]   num;
	logic [RECIP_BITS-1:0] recip;

	always_comb begin
		num   = acc_s4[ACC_BITS-1] ? '0 : acc_s4[NUM_BITS-1:0];
		recip = hi_s4 ? HIGH_RECIP : LOW_RECIP;
	end

	always_ff @(posedge clk) begin
		if (en[4] && v_s[3]) begin
			prod_s5 <= PROD_BITS'(num) * PROD_BITS'(recip);
			hi_s5   <= hi_s4;
			sign_s5 <= sign_s4;
		end
	end

	// Stage 6: shift out the quotient and apply the sign.
	logic [QUOT_BITS-1:0]   quot;
	logic [VALUE_BITS-1:0]  mag;

	always_comb begin
		quot = hi_s5 ? prod_s5[HIGH_SHIFT +: QUOT_BITS] : prod_s5[LOW_SHIFT +: QUOT_BITS];
		mag  = VALUE_BITS'(quot);
	end

	always_ff @(posedge clk) begin
		if (en[5] && v_s[4]) begin
			value_s6 <= sign_s5 ? -$signed(mag) : $signed(mag);
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[NST-1];
	assign out_value = value_s6;
endmodule

// ===== src/integer_degree_sine_cosine_unit.sv =====
// ----------------------------------------------------------------------------
// integer_degree_sine_cosine_unit
// Sine or cosine of a whole-degree angle, returned in signed ten-thousandths
// (-9999..9999). Cosine is taken as the sine of angle + 90 at one extra bit,
// so it never overflows; any angle is reduced modulo 360 and folded into
// 0..90 before a cubic is evaluated. The unit is fully pipelined and takes
// one beat per cycle while the result is taken. From input beat to result
// beat a beat passes one input stage, one modulo stage per byte of the angle
// magnitude above its low three bits, then fold, three Horner steps, the
// reciprocal multiply and the output register. Each stage holds its beat
// while the stage after it is full and stalled, so bubbles close up and a
// stalled result stops new beats only once every stage holds one.
// ----------------------------------------------------------------------------
module integer_degree_sine_cosine_unit import idsc_pkg::*; #(
	parameter int ANGLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	idsc_in_if.sink     operand,
	idsc_out_if.source  result
);
	localparam int HI_BITS = ANGLE_BITS - LOW_BITS;

	logic                  v_s1;
	logic                  en_s1;
	logic                  neg_s1;
	logic [ANGLE_BITS-1:0] mag_s1;
	logic                  mod_ready;
	logic                  red_valid;
	logic                  red_ready;
	red_t                  red;

	// Widen by one bit before the cosine offset, then take the magnitude;
	// it always fits back into ANGLE_BITS unsigned bits.
	logic signed [ANGLE_BITS:0] sum;
	logic [ANGLE_BITS:0]        abs_sum;

	always_comb begin
		sum     = (ANGLE_BITS+1)'(operand.angle) +
		          (operand.op ? (ANGLE_BITS+1)'(90) : '0);
		abs_sum = sum[ANGLE_BITS] ? -sum : sum;
	end

	assign en_s1         = !v_s1 || mod_ready;
	assign operand.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= operand.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && operand.valid) begin
			neg_s1 <= sum[ANGLE_BITS];
			mag_s1 <= abs_sum[ANGLE_BITS-1:0];
		end
	end

	idsc_mod45 #(
		.HI_BITS (HI_BITS)
	) u_mod45 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (mod_ready),
		.in_hi     (mag_s1[ANGLE_BITS-1:LOW_BITS]),
		.in_low    (mag_s1[LOW_BITS-1:0]),
		.in_neg    (neg_s1),
		.out_valid (red_valid),
		.out_ready (red_ready),
		.out_red   (red)
	);

	idsc_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (red_valid),
		.in_ready  (red_ready),
		.in_red    (red),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_value (result.value)
	);
endmodule

// ===== dv/tb_integer_degree_sine_cosine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_degree_sine_cosine_unit
// Drives angle beats with a sine or cosine select into the unit and checks each
// result beat against a cycle-free integer model of the quadrant fold and the
// two cubic fits. A directed set of corner angles comes first, then random
// angles under three idling patterns on the two channels.
// ----------------------------------------------------------------------------
module tb_integer_degree_sine_cosine_unit;
	import idsc_pkg::*;

	localparam int ANGLE_BITS = 16;
	localparam logic OP_SINE   = 1'b0;
	localparam logic OP_COSINE = 1'b1;
	localparam int RANDOM_PER_PHASE = 434;
	localparam int DRAIN_CYCLES     = 30;

	localparam longint LOW_FIT [4]  = '{-81, -277, 1747900, -1600};
	localparam longint HIGH_FIT [4] = '{336, -161420, 75484, 999960000};

	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] angle;
		logic                         op;
	} angle_beat_t;

	logic clk;
	logic arst_n;

	idsc_in_if #(.ANGLE_BITS(ANGLE_BITS)) operand_if ();
	idsc_out_if                           result_if ();

	integer_degree_sine_cosine_unit #(
		.ANGLE_BITS(ANGLE_BITS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.operand(operand_if),
		.result (result_if)
	);

	angle_beat_t                  pending_angles[$];
	logic signed [VALUE_BITS-1:0] expected_values[$];
	int                           send_idle_pct;
	int                           recv_idle_pct;
	int                           error_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint cubic_at(input longint coef [4], input longint t);
		longint acc;
		acc = 0;
		for (int i = 0; i < 4; i++) begin
			acc = acc * t + coef[i];
		end
		return acc;
	endfunction

	// Cosine is the sine of angle + 90, formed at 64 bits so the sum cannot wrap.
	function automatic logic signed [VALUE_BITS-1:0] sine_cosine_of(
		input logic signed [ANGLE_BITS-1:0] angle,
		input logic                         op
	);
		longint deg;
		longint mag;
		longint r;
		longint v;
		bit     neg_angle;
		bit     neg_half;
		deg = longint'(angle);
		if (op == OP_COSINE) begin
			deg = deg + 90;
		end
		neg_angle = deg < 0;
		mag = neg_angle ? -deg : deg;
		r = mag % 360;
		neg_half = r > 180;
		if (neg_half) begin
			r = r - 180;
		end
		if (r > 90) begin
			r = 180 - r;
		end
		if (r <= 45) begin
			v = cubic_at(LOW_FIT, r) / 10000;
		end else begin
			v = cubic_at(HIGH_FIT, 90 - r) / 100000;
		end
		if (neg_half) begin
			v = -v;
		end
		if (neg_angle) begin
			v = -v;
		end
		return v[VALUE_BITS-1:0];
	endfunction

	// Driver: a new beat is offered only once the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operand_if.valid <= 1'b0;
			operand_if.angle <= '0;
			operand_if.op    <= OP_SINE;
		end else if (!operand_if.valid || operand_if.ready) begin
			if (pending_angles.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				operand_if.valid <= 1'b1;
				operand_if.angle <= pending_angles[0].angle;
				operand_if.op    <= pending_angles[0].op;
				void'(pending_angles.pop_front());
			end else begin
				operand_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: predicts on each accepted angle beat and checks each result beat.
	always @(posedge clk) begin
		logic signed [VALUE_BITS-1:0] want;
		if (arst_n) begin
			if (operand_if.valid && operand_if.ready) begin
				expected_values.push_back(sine_cosine_of(operand_if.angle, operand_if.op));
			end
			if (result_if.valid && result_if.ready) begin
				if (expected_values.size() == 0) begin
					$error("value: no result expected, actual %0d", result_if.value);
					error_count++;
				end else begin
					want = expected_values.pop_front();
					if (result_if.value !== want) begin
						$error("value: expected %0d, actual %0d", want, result_if.value);
						error_count++;
					end
				end
			end
		end
	end

	task automatic queue_random_angles(input int count);
		angle_beat_t beat;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(1) == 0) begin
				beat.angle = ANGLE_BITS'($urandom);
			end else begin
				beat.angle = ANGLE_BITS'($signed($urandom_range(1440)) - 720);
			end
			beat.op = 1'($urandom_range(1));
			pending_angles.push_back(beat);
		end
	endtask

	task automatic wait_for_sent;
		while (pending_angles.size() != 0 || operand_if.valid) begin
			@(negedge clk);
		end
	endtask

	initial begin
		int          corners [12];
		angle_beat_t beat;
		corners = '{0, 1, -1, 45, 46, 90, 180, 270, 359, 360, -32768, 32767};
		error_count   = 0;
		send_idle_pct = 29;
		recv_idle_pct = 55;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (corners[i]) begin
			beat.angle = ANGLE_BITS'(corners[i]);
			beat.op    = OP_SINE;
			pending_angles.push_back(beat);
			beat.op    = OP_COSINE;
			pending_angles.push_back(beat);
		end
		queue_random_angles(RANDOM_PER_PHASE);
		wait_for_sent();

		send_idle_pct = 55;
		recv_idle_pct = 29;
		queue_random_angles(RANDOM_PER_PHASE);
		wait_for_sent();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_angles(RANDOM_PER_PHASE);
		wait_for_sent();

		while (expected_values.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0) begin
			$display("tb_integer_degree_sine_cosine_unit: done, clean");
		end else begin
			$display("tb_integer_degree_sine_cosine_unit: done, errors");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_integer_degree_sine_cosine_unit: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
src/idsc_pkg.sv
src/idsc_in_if.sv
src/idsc_out_if.sv
src/idsc_mod45.sv
src/idsc_poly.sv
src/integer_degree_sine_cosine_unit.sv
dv/tb_integer_degree_sine_cosine_unit.sv
